[rtl/core/bfrc_pkg.sv]
// Shared types, constants and the CRC-16 CCITT byte update for the frame receiver checker.
package bfrc_pkg;

    localparam int FRAME_LEN_DEFAULT = 15;
    localparam int CNT_W = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LIMIT_US = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED = 2'd2;

    localparam logic [63:0] DEVICE_ADDRESS_RESET = 64'd0;
    localparam logic [15:0] GAP_LIMIT_RESET = 16'd30000;
    localparam logic [15:0] CRC_SEED_RESET = 16'd42;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0] FILL_BYTE = 8'h11;
    localparam logic [7:0] TYPE_DATA_REQ = 8'h01;

    // Fixed byte positions inside a frame
    localparam logic [CNT_W-1:0] POS_ADDR_FIRST = 4'd1;
    localparam logic [CNT_W-1:0] POS_ADDR_LAST = 4'd8;
    localparam logic [CNT_W-1:0] POS_TYPE = 4'd9;
    localparam logic [CNT_W-1:0] POS_CMD = 4'd10;

    localparam logic [2:0] VERDICT_CRC_ERROR = 3'd0;
    localparam logic [2:0] VERDICT_BROADCAST = 3'd1;
    localparam logic [2:0] VERDICT_ADDR_MISMATCH = 3'd2;
    localparam logic [2:0] VERDICT_DATA_REQUEST = 3'd3;
    localparam logic [2:0] VERDICT_UNKNOWN_TYPE = 3'd4;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] gap_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] command_byte;
    } out_item_t;

    typedef struct packed {
        logic [63:0] device_address;
        logic [15:0] gap_limit_us;
        logic [15:0] crc_seed;
    } cfg_t;

    // MSB-first CCITT update over one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/bfrc_cfg.sv]
// Configuration register file: device address, gap limit and CRC seed.
module bfrc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bfrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfrc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bfrc_pkg::cfg_t                    cfg
);

    bfrc_pkg::cfg_t cfg_reg;
    bfrc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bfrc_pkg::CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data;
                bfrc_pkg::CFG_GAP_LIMIT_US:   cfg_next.gap_limit_us = cfg_data[15:0];
                bfrc_pkg::CFG_CRC_SEED:       cfg_next.crc_seed = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= bfrc_pkg::DEVICE_ADDRESS_RESET;
            cfg_reg.gap_limit_us <= bfrc_pkg::GAP_LIMIT_RESET;
            cfg_reg.crc_seed <= bfrc_pkg::CRC_SEED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // Writes to an unused index leave every register alone
    a_unused_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index != bfrc_pkg::CFG_DEVICE_ADDRESS
                && cfg_index != bfrc_pkg::CFG_GAP_LIMIT_US
                && cfg_index != bfrc_pkg::CFG_CRC_SEED) |=> $stable(cfg_reg))
        else $error("cfg: write to unused index changed a register");

    a_seed_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == bfrc_pkg::CFG_CRC_SEED)
            |=> cfg_reg.crc_seed == $past(cfg_data[15:0]))
        else $error("cfg: CRC seed write lost");

endmodule

[rtl/core/bfrc_frame.sv]
// Frame tracker: byte position, running CRC, fill and address flags, verdict on the last byte.
module bfrc_frame #(
    parameter int FRAME_LEN = bfrc_pkg::FRAME_LEN_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfrc_pkg::cfg_t       cfg,
    input  logic                 en,
    input  bfrc_pkg::in_item_t   item,
    output logic                 res_valid,
    output bfrc_pkg::out_item_t  res
);

    localparam logic [bfrc_pkg::CNT_W:0] LEN_CNT = (bfrc_pkg::CNT_W + 1)'(FRAME_LEN);
    localparam logic [bfrc_pkg::CNT_W-1:0] POS_LAST = bfrc_pkg::CNT_W'(FRAME_LEN - 1);
    localparam logic [bfrc_pkg::CNT_W-1:0] POS_CRC_LO = bfrc_pkg::CNT_W'(FRAME_LEN - 2);

    logic [bfrc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [15:0]                crc_reg, crc_next;
    logic [7:0]                 crc_lo_reg, crc_lo_next;
    logic                       fill_reg, fill_next;
    logic                       addr_ok_reg, addr_ok_next;
    logic [7:0]                 type_reg, type_next;
    logic [7:0]                 cmd_reg, cmd_next;

    logic [bfrc_pkg::CNT_W-1:0] pos_raw;
    logic [bfrc_pkg::CNT_W-1:0] pos;
    logic [2:0]                 pos_m1;
    logic [15:0]                crc_base;
    logic                       fill_base;
    logic                       addr_ok_base;
    logic [7:0]                 want_byte;
    logic                       is_last;
    logic                       crc_ok;
    logic [2:0]                 verdict;

    always_comb
    begin
        // Drop the partial frame on a long gap
        pos_raw = (item.gap_us > cfg.gap_limit_us) ? '0 : count_reg;
        pos = ({1'b0, pos_raw} >= LEN_CNT) ? '0 : pos_raw;
        pos_m1 = pos[2:0] - 3'd1;
        want_byte = cfg.device_address[pos_m1*8 +: 8];
        is_last = (pos == POS_LAST);

        crc_base = (pos == '0) ? cfg.crc_seed : crc_reg;
        fill_base = (pos == '0) ? 1'b1 : fill_reg;
        addr_ok_base = (pos == '0) ? 1'b1 : addr_ok_reg;

        crc_next = crc_base;
        fill_next = fill_base;
        if (pos < POS_CRC_LO)
        begin
            crc_next = bfrc_pkg::crc_feed(crc_base, item.rx_byte);
            fill_next = fill_base & (item.rx_byte == bfrc_pkg::FILL_BYTE);
        end

        addr_ok_next = addr_ok_base;
        if (pos >= bfrc_pkg::POS_ADDR_FIRST && pos <= bfrc_pkg::POS_ADDR_LAST)
        begin
            addr_ok_next = addr_ok_base & (item.rx_byte == want_byte);
        end

        type_next = (pos == bfrc_pkg::POS_TYPE) ? item.rx_byte : type_reg;
        cmd_next = (pos == bfrc_pkg::POS_CMD) ? item.rx_byte : cmd_reg;
        crc_lo_next = (pos == POS_CRC_LO) ? item.rx_byte : crc_lo_reg;
        count_next = is_last ? '0 : pos + 4'd1;

        crc_ok = (crc_lo_reg == crc_base[7:0]) && (item.rx_byte == crc_base[15:8]);
        priority if (!crc_ok)
        begin
            verdict = bfrc_pkg::VERDICT_CRC_ERROR;
        end
        else if (fill_base)
        begin
            verdict = bfrc_pkg::VERDICT_BROADCAST;
        end
        else if (!addr_ok_base)
        begin
            verdict = bfrc_pkg::VERDICT_ADDR_MISMATCH;
        end
        else if (type_reg == bfrc_pkg::TYPE_DATA_REQ)
        begin
            verdict = bfrc_pkg::VERDICT_DATA_REQUEST;
        end
        else
        begin
            verdict = bfrc_pkg::VERDICT_UNKNOWN_TYPE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg <= bfrc_pkg::CRC_SEED_RESET;
            crc_lo_reg <= '0;
            fill_reg <= 1'b1;
            addr_ok_reg <= 1'b1;
            type_reg <= '0;
            cmd_reg <= '0;
        end
        else if (en)
        begin
            count_reg <= count_next;
            crc_reg <= crc_next;
            crc_lo_reg <= crc_lo_next;
            fill_reg <= fill_next;
            addr_ok_reg <= addr_ok_next;
            type_reg <= type_next;
            cmd_reg <= cmd_next;
        end
    end

    assign res_valid = en && is_last;
    assign res.verdict = verdict;
    assign res.command_byte = cmd_reg;

    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < LEN_CNT)
        else $error("frame: byte position beyond frame length");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> count_reg == '0)
        else $error("frame: position not cleared after last byte");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(count_reg) && $stable(crc_reg))
        else $error("frame: state moved without a request");

endmodule

[rtl/core/bus_frame_receiver_checker.sv]
// Top level of the framed bus receiver with CRC-16 CCITT check and request classification.
// Result timing: out_valid rises at the clock edge at which the last byte of a frame leaves the
//   input register, which a finished result waiting on a stalled output can delay.
// Throughput: one byte per cycle; the CRC byte update and compares sit in one stage.
// The input register stalls only while a finished result waits on a stalled output.
// Reset (rst_n low, asynchronous) empties both stages, starts at frame position zero and
//   loads address 0, gap limit 30000 us and CRC seed 42.
module bus_frame_receiver_checker #(
    parameter int FRAME_LEN = bfrc_pkg::FRAME_LEN_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bfrc_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output bfrc_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [bfrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bfrc_pkg::cfg_t      cfg;
    logic                s1_valid_reg, s1_valid_next;
    bfrc_pkg::in_item_t  s1_data_reg;
    logic                out_valid_reg, out_valid_next;
    bfrc_pkg::out_item_t out_data_reg;
    logic                s1_go;
    logic                s1_fire;
    logic                res_valid;
    bfrc_pkg::out_item_t res;

    bfrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bfrc_frame #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .en        (s1_fire),
        .item      (s1_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Advance whenever the output register is free or being drained
    assign s1_go = !(out_valid_reg && out_stall);
    assign s1_fire = s1_valid_reg && s1_go;
    assign in_stall = s1_valid_reg && !s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
        if (res_valid && s1_go)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("top: input stalled with nothing to hold");

    a_blocked_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_data_reg))
        else $error("top: waiting result overwritten");

    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire))
        else $error("top: result without a processed byte");

endmodule

[bench/tb_bus_frame_receiver_checker.sv]
// Testbench for the framed bus receiver checker: directed and random frames against a predictor.
module tb_bus_frame_receiver_checker;

    localparam int FRAME_LEN = bfrc_pkg::FRAME_LEN_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_BYTES = 115;

    typedef enum int {FK_DATA, FK_UNKNOWN, FK_MISMATCH, FK_BROADCAST} frame_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    bfrc_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bfrc_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [bfrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bfrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted register copy and frame state
    logic [63:0] cfg_addr = bfrc_pkg::DEVICE_ADDRESS_RESET;
    logic [15:0] cfg_gap = bfrc_pkg::GAP_LIMIT_RESET;
    logic [15:0] cfg_seed = bfrc_pkg::CRC_SEED_RESET;
    int pos = 0;
    logic [15:0] run_crc = bfrc_pkg::CRC_SEED_RESET;
    logic [7:0] crc_low = 8'h00;
    logic fill_flag = 1'b1;
    logic addr_flag = 1'b1;
    logic [7:0] type_b = 8'h00;
    logic [7:0] cmd_b = 8'h00;

    bfrc_pkg::out_item_t pending_verdicts[$];
    bfrc_pkg::out_item_t oldest_verdict;
    logic [7:0] frame_buf [FRAME_LEN];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int verdicts_checked = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int errors;

    bus_frame_receiver_checker #(
        .FRAME_LEN(FRAME_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bit-serial CCITT, MSB first
    function automatic logic [15:0] ccitt_next(input logic [15:0] r, input logic [7:0] d);
        logic [15:0] acc;
        logic fb;
        acc = r;
        for (int k = 7; k >= 0; k--)
        begin
            fb = acc[15] ^ d[k];
            acc = {acc[14:0], 1'b0};
            if (fb)
            begin
                acc = acc ^ bfrc_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    // Advance the frame state by one accepted byte; queue the verdict on the last byte
    task automatic classify_byte(input bfrc_pkg::in_item_t it);
        int p;
        bfrc_pkg::out_item_t res;
        logic [7:0] b;
        b = it.rx_byte;
        if (it.gap_us > cfg_gap)
        begin
            pos = 0;
        end
        p = pos;
        if (p >= FRAME_LEN)
        begin
            p = 0;
        end
        if (p == 0)
        begin
            run_crc = cfg_seed;
            fill_flag = 1'b1;
            addr_flag = 1'b1;
        end
        if (p < FRAME_LEN - 2)
        begin
            run_crc = ccitt_next(run_crc, b);
            if (b != bfrc_pkg::FILL_BYTE)
            begin
                fill_flag = 1'b0;
            end
        end
        if (p >= 1 && p <= 8)
        begin
            if (b != cfg_addr[8*(p-1) +: 8])
            begin
                addr_flag = 1'b0;
            end
        end
        if (p == 9)
        begin
            type_b = b;
        end
        if (p == 10)
        begin
            cmd_b = b;
        end
        if (p == FRAME_LEN - 2)
        begin
            crc_low = b;
        end
        if (p == FRAME_LEN - 1)
        begin
            if (crc_low != run_crc[7:0] || b != run_crc[15:8])
            begin
                res.verdict = bfrc_pkg::VERDICT_CRC_ERROR;
            end
            else if (fill_flag)
            begin
                res.verdict = bfrc_pkg::VERDICT_BROADCAST;
            end
            else if (!addr_flag)
            begin
                res.verdict = bfrc_pkg::VERDICT_ADDR_MISMATCH;
            end
            else if (type_b == bfrc_pkg::TYPE_DATA_REQ)
            begin
                res.verdict = bfrc_pkg::VERDICT_DATA_REQUEST;
            end
            else
            begin
                res.verdict = bfrc_pkg::VERDICT_UNKNOWN_TYPE;
            end
            res.command_byte = cmd_b;
            pending_verdicts.push_back(res);
            pos = 0;
        end
        else
        begin
            pos = p + 1;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Compare each accepted result with the oldest predicted verdict
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                note_mismatch("unexpected result verdict", 8'h00, {5'd0, out_data.verdict});
            end
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                verdicts_checked++;
                if (out_data.verdict != oldest_verdict.verdict)
                begin
                    note_mismatch("verdict", {5'd0, oldest_verdict.verdict},
                                  {5'd0, out_data.verdict});
                end
                if (out_data.command_byte != oldest_verdict.command_byte)
                begin
                    note_mismatch("command_byte", oldest_verdict.command_byte,
                                  out_data.command_byte);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no request moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic [15:0] g);
        bfrc_pkg::in_item_t it;
        it.rx_byte = b;
        it.gap_us = g;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        classify_byte(it);
        bytes_sent++;
    endtask

    // Drop valid, drain all verdicts, then let the pipeline settle
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bfrc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bfrc_pkg::CFG_DEVICE_ADDRESS: cfg_addr = val;
            bfrc_pkg::CFG_GAP_LIMIT_US: cfg_gap = val[15:0];
            bfrc_pkg::CFG_CRC_SEED: cfg_seed = val[15:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic logic [15:0] in_frame_gap();
        int r;
        r = $urandom_range(7);
        if (r == 0)
        begin
            return cfg_gap;
        end
        if (r == 1)
        begin
            return 16'd0;
        end
        return 16'($urandom_range(cfg_gap));
    endfunction

    task automatic make_frame(input frame_kind_t kind);
        int i;
        logic [7:0] t;
        for (i = 0; i < FRAME_LEN; i++)
        begin
            frame_buf[i] = 8'($urandom);
        end
        if (kind == FK_BROADCAST)
        begin
            for (i = 0; i < FRAME_LEN - 2; i++)
            begin
                frame_buf[i] = bfrc_pkg::FILL_BYTE;
            end
        end
        else
        begin
            for (i = 1; i <= 8; i++)
            begin
                frame_buf[i] = cfg_addr[8*(i-1) +: 8];
            end
            t = 8'($urandom);
            if (t == bfrc_pkg::TYPE_DATA_REQ)
            begin
                t = ~t;
            end
            case (kind)
                FK_DATA: frame_buf[bfrc_pkg::POS_TYPE] = bfrc_pkg::TYPE_DATA_REQ;
                FK_UNKNOWN: frame_buf[bfrc_pkg::POS_TYPE] = t;
                default:
                begin
                    i = $urandom_range(8, 1);
                    frame_buf[i] = frame_buf[i] ^ 8'(1 << $urandom_range(7));
                    frame_buf[bfrc_pkg::POS_TYPE] = 8'($urandom);
                end
            endcase
        end
    endtask

    // Append the CRC under the current seed; optionally flip one bit anywhere
    task automatic seal_frame(input bit corrupt);
        logic [15:0] c;
        int i;
        c = cfg_seed;
        for (i = 0; i < FRAME_LEN - 2; i++)
        begin
            c = ccitt_next(c, frame_buf[i]);
        end
        frame_buf[FRAME_LEN-2] = c[7:0];
        frame_buf[FRAME_LEN-1] = c[15:8];
        if (corrupt)
        begin
            i = $urandom_range(FRAME_LEN - 1);
            frame_buf[i] = frame_buf[i] ^ 8'(1 << $urandom_range(7));
        end
    endtask

    task automatic send_frame_bytes(input int first, input int last);
        int i;
        logic [15:0] g;
        // Without a restart gap, pad until the block sits at frame start
        if (first == 0 && cfg_gap == 16'hFFFF)
        begin
            while (pos != 0)
            begin
                send_item(8'($urandom), in_frame_gap());
            end
        end
        for (i = first; i <= last; i++)
        begin
            if (i == 0 && cfg_gap != 16'hFFFF)
            begin
                g = 16'($urandom_range(32'hFFFF, cfg_gap + 1));
            end
            else
            begin
                g = in_frame_gap();
            end
            send_item(frame_buf[i], g);
        end
    endtask

    task automatic send_random_frame();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 90)
        begin
            if (r < 30)
            begin
                make_frame(FK_DATA);
            end
            else if (r < 45)
            begin
                make_frame(FK_UNKNOWN);
            end
            else if (r < 57)
            begin
                make_frame(FK_MISMATCH);
            end
            else if (r < 65)
            begin
                make_frame(FK_BROADCAST);
            end
            else
            begin
                make_frame(frame_kind_t'($urandom_range(3)));
            end
            seal_frame(r >= 65 && r < 80);
            if (r < 80)
            begin
                send_frame_bytes(0, FRAME_LEN - 1);
            end
            else
            begin
                send_frame_bytes(0, $urandom_range(FRAME_LEN - 2));
            end
        end
        else
        begin
            n = $urandom_range(20, 1);
            repeat (n) send_item(8'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_data_request();
        make_frame(FK_DATA);
        frame_buf[0] = 8'hFF;
        frame_buf[bfrc_pkg::POS_CMD] = 8'h00;
        seal_frame(0);
        send_frame_bytes(0, FRAME_LEN - 1);
        quiesce();
    endtask

    task automatic test_broadcast();
        make_frame(FK_BROADCAST);
        seal_frame(0);
        send_frame_bytes(0, FRAME_LEN - 1);
        quiesce();
    endtask

    task automatic test_crc_error();
        make_frame(FK_DATA);
        frame_buf[bfrc_pkg::POS_CMD] = 8'hFF;
        seal_frame(1);
        send_frame_bytes(0, FRAME_LEN - 1);
        quiesce();
    endtask

    // Break off a frame and restart with a long gap
    task automatic test_gap_restart();
        make_frame(FK_UNKNOWN);
        seal_frame(0);
        send_frame_bytes(0, 5);
        send_frame_bytes(0, FRAME_LEN - 1);
        quiesce();
    endtask

    // A new seed must not touch the frame in progress
    task automatic test_seed_mid_frame();
        make_frame(FK_MISMATCH);
        seal_frame(0);
        send_frame_bytes(0, 6);
        quiesce();
        write_reg(bfrc_pkg::CFG_CRC_SEED, 64'hBEEF);
        send_frame_bytes(7, FRAME_LEN - 1);
        quiesce();
    endtask

    task automatic test_random_traffic(input int phase, input int tx_pct, input int rx_pct);
        logic [63:0] a;
        logic [15:0] g;
        logic [15:0] s;
        int start;
        a = {$urandom, $urandom};
        g = 16'($urandom);
        s = 16'($urandom);
        case (phase)
            0:
            begin
                a = '1;
                g = 16'd0;
                s = 16'hFFFF;
            end
            1:
            begin
                g = 16'hFFFF;
                s = 16'h0000;
            end
            2: a = '0;
            3: g = bfrc_pkg::GAP_LIMIT_RESET;
            5: g = 16'd1;
            default: ;
        endcase
        quiesce();
        write_reg(bfrc_pkg::CFG_DEVICE_ADDRESS, a);
        write_reg(bfrc_pkg::CFG_GAP_LIMIT_US, {48'd0, g});
        write_reg(bfrc_pkg::CFG_CRC_SEED, {48'd0, s});
        settings_used++;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            send_random_frame();
        end
        quiesce();
    endtask

    // Hold the output long enough that the input must stall
    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        repeat (4)
        begin
            make_frame(frame_kind_t'($urandom_range(3)));
            seal_frame(0);
            send_frame_bytes(0, FRAME_LEN - 1);
        end
        quiesce();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 24;
        rx_idle_pct = 55;
        settings_used = 1;
        test_data_request();
        test_broadcast();
        test_crc_error();
        test_gap_restart();
        test_seed_mid_frame();
        test_random_traffic(0, 24, 55);
        test_random_traffic(1, 24, 55);
        test_random_traffic(2, 55, 24);
        test_random_traffic(3, 55, 24);
        test_random_traffic(4, 0, 0);
        test_random_traffic(5, 0, 0);
        test_output_hold_off();
        quiesce();
        errors = mismatches + pending_verdicts.size();
        $display("Summary: %0d bytes sent, %0d verdicts checked, %0d register writes, %0d settings",
                 bytes_sent, verdicts_checked, reg_writes, settings_used);
        $display("Covered all verdicts, gap restarts, a mid-frame seed change, output hold-off");
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/bfrc_pkg.sv
rtl/core/bfrc_cfg.sv
rtl/core/bfrc_frame.sv
rtl/core/bus_frame_receiver_checker.sv
bench/tb_bus_frame_receiver_checker.sv
